/* hw/rtl/swm_pkg.sv */
package swm_pkg;

	localparam int HASH_W   = 64;
	localparam int ID_W     = 32;
	localparam int OFFSET_W = 24;
	localparam int WLEN_W   = 7;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd10;

	// Stream words: input is hash then id, output is hash, id then offset.
	localparam int S_DATA_W = HASH_W + ID_W;
	localparam int M_DATA_W = HASH_W + ID_W + OFFSET_W;

endpackage

/* hw/rtl/sliding_window_minimizer_top.sv */
// K-mer window minimizer. Each input word carries one k-mer hash, its read id and, on tlast,
// the end of the read; an output word carries the minimum hash of the current window with the
// id and offset stored alongside it, given once the window is full and only when it differs
// from the hash last given. Candidates live in a ring held in a two-read, one-write memory
// with registered reads. Once an item is taken, the sequencer removes the candidates that expire
// from the front or are dropped from the back, one per memory access, and then, unless the
// position has saturated, stores the new candidate; every candidate leaves at most once. No new
// item is taken until the last is done, and a result waiting at the output holds back the next
// item only if that item also has a result to give. The window length register is taken through
// cfg_data and applies from the next item on.
module sliding_window_minimizer_top
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW    = 64,
	parameter int POSITION_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // kmer_hash[63:0], sequence_id[95:64]
	input  logic                s_tlast,  // read_end
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // min_hash[63:0], min_sequence_id[95:64],
	                                      // offset within the read[119:96]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [WLEN_W-1:0]   cfg_data
);

	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int PW  = POSITION_BITS;
	localparam int PCW = POSITION_BITS + 1;
	localparam int EW  = HASH_W + PW + ID_W;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	state_t              state_q, state_d;
	logic [WLEN_W-1:0]   cfg_q;
	logic [HASH_W-1:0]   hash_q;
	logic [ID_W-1:0]     id_q;
	logic                last_q;
	logic [CW-1:0]       wlen_q;
	logic [AW-1:0]       head_q, head_d;
	logic [CW-1:0]       count_q, count_d;
	logic [PCW-1:0]      position_q, position_d;
	logic [HASH_W-1:0]   last_hash_q, last_hash_d;
	logic                have_emitted_q, have_emitted_d;
	logic                m_tvalid_q, m_tvalid_d;
	logic [HASH_W-1:0]   out_hash_q;
	logic [ID_W-1:0]     out_id_q;
	logic [OFFSET_W-1:0] out_off_q;

	logic                s_fire;
	logic [CW-1:0]       wlen_clamped;
	logic                mem_we;
	logic [AW-1:0]       waddr, raddr_front, raddr_back;
	logic [EW-1:0]       wdata, rdata_front, rdata_back;
	logic [HASH_W-1:0]   fr_hash, bk_hash, sel_hash;
	logic [PW-1:0]       fr_pos, sel_pos, pos_cur, age;
	logic [ID_W-1:0]     fr_id, sel_id;
	logic                saturated, expire, dominate, in_window, emit, out_free;
	logic                load_out, item_done;

	function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= (AW+1)'(MAX_WINDOW)) ? s - (AW+1)'(MAX_WINDOW) : s;
		return r[AW-1:0];
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_off_q, out_id_q, out_hash_q};

	always_comb begin
		if (cfg_q == '0) begin
			wlen_clamped = CW'(1);
		end else if (int'(cfg_q) > MAX_WINDOW) begin
			wlen_clamped = CW'(MAX_WINDOW);
		end else begin
			wlen_clamped = CW'(cfg_q);
		end
	end

	// Entry layout: hash in the low bits, then position, then id.
	assign fr_hash = rdata_front[HASH_W-1:0];
	assign fr_pos  = rdata_front[HASH_W +: PW];
	assign fr_id   = rdata_front[HASH_W+PW +: ID_W];
	assign bk_hash = rdata_back[HASH_W-1:0];

	assign pos_cur   = position_q[PW-1:0];
	assign saturated = position_q[PW];
	assign age       = pos_cur - fr_pos;
	assign expire    = (count_q != '0) && (age >= PW'(wlen_q));
	assign dominate  = (count_q != '0) && (bk_hash >= hash_q);
	assign in_window = (position_q + 1'b1) >= PCW'(wlen_q);

	// With an empty window the new candidate is itself the front.
	assign sel_hash = (count_q == '0) ? hash_q : fr_hash;
	assign sel_pos  = (count_q == '0) ? pos_cur : fr_pos;
	assign sel_id   = (count_q == '0) ? id_q : fr_id;

	assign emit     = in_window && (!have_emitted_q || sel_hash != last_hash_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign waddr = ring_wrap({1'b0, head_q} + (AW+1)'(count_q));
	assign wdata = {id_q, pos_cur, hash_q};

	always_comb begin
		state_d        = state_q;
		head_d         = head_q;
		count_d        = count_q;
		position_d     = position_q;
		last_hash_d    = last_hash_q;
		have_emitted_d = have_emitted_q;
		m_tvalid_d     = m_tvalid_q && !m_tready;
		mem_we         = 1'b0;
		load_out       = 1'b0;
		item_done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				priority if (saturated) begin
					item_done = 1'b1;
				end else if (expire) begin
					head_d  = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
				end else if (dominate) begin
					count_d = count_q - 1'b1;
				end else if (!(emit && !out_free)) begin
					mem_we     = 1'b1;
					count_d    = count_q + 1'b1;
					position_d = position_q + 1'b1;
					item_done  = 1'b1;
					if (emit) begin
						load_out       = 1'b1;
						m_tvalid_d     = 1'b1;
						last_hash_d    = sel_hash;
						have_emitted_d = 1'b1;
					end
				end else begin
					// Result ready but the output word has not been taken yet.
				end
				if (item_done) begin
					state_d = ST_IDLE;
					if (last_q) begin
						head_d     = '0;
						count_d    = '0;
						position_d = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Read addresses follow the next head and count, so the data seen in any cycle belongs
	// to the front and back of the window as it stands in that cycle.
	assign raddr_front = head_d;
	assign raddr_back  = (count_d == '0) ? head_d
	                   : ring_wrap({1'b0, head_d} + (AW+1)'(count_d) - 1'b1);

	swm_mem #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_front),
		.raddr_b (raddr_back),
		.rdata_a (rdata_front),
		.rdata_b (rdata_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			position_q     <= '0;
			last_hash_q    <= '0;
			have_emitted_q <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q        <= state_d;
			head_q         <= head_d;
			count_q        <= count_d;
			position_q     <= position_d;
			last_hash_q    <= last_hash_d;
			have_emitted_q <= have_emitted_d;
			m_tvalid_q     <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= WLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			hash_q <= s_tdata[HASH_W-1:0];
			id_q   <= s_tdata[HASH_W +: ID_W];
			last_q <= s_tlast;
			wlen_q <= wlen_clamped;
		end
		if (load_out) begin
			out_hash_q <= sel_hash;
			out_id_q   <= sel_id;
			out_off_q  <= OFFSET_W'(sel_pos);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WINDOW))
		else $error("candidate count beyond ring depth");

	a_position_hold: assert property (@(posedge clk) disable iff (!arst_n)
		position_q[PW] |-> (position_q[PW-1:0] == '0))
		else $error("position ran past its limit");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < CW'(MAX_WINDOW)))
		else $error("candidate written into a full ring");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_WORK))
		else $error("output word raised outside item processing");

	a_read_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK && item_done && last_q) |=>
			(count_q == '0 && head_q == '0 && position_q == '0))
		else $error("window not cleared after end of read");

endmodule

/* hw/rtl/swm_mem.sv */
module swm_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write-first: a read of the entry being written returns the new word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

endmodule
